@@ src/svdcov_pkg.sv @@
// ----------------------------------------------------------------------------
// svdcov_pkg
// Shared types and constants of the covariance-from-SVD-factors block.
// ----------------------------------------------------------------------------
package svdcov_pkg;

    // Request selector codes.
    localparam logic [1:0] FN_LOAD_W = 2'd0;
    localparam logic [1:0] FN_LOAD_V = 2'd1;
    localparam logic [1:0] FN_ROW    = 2'd2;

    // Width of the size register and of row and column indexes.
    localparam int SIZE_W = 5;
    localparam int IX_W   = 4;

    // Exact accumulator: each term is below 2^94 in magnitude and at most
    // sixteen terms are summed, so a signed 100-bit sum never overflows.
    localparam int ACC_W  = 100;
    // Q20.76 to Q32.32 drops 44 fraction bits.
    localparam int RND_SH = 44;

    // Saturated weight.
    localparam logic [31:0] WT_SAT = 32'hFFFF_FFFF;

    // Reset value of the size register.
    localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

    // One input request.
    typedef struct packed {
        logic [1:0]         func;
        logic [IX_W-1:0]    row;
        logic [IX_W-1:0]    col;
        logic signed [31:0] value;
    } t_in;

    // One covariance element.
    typedef struct packed {
        logic [IX_W-1:0]    out_row;
        logic [IX_W-1:0]    out_col;
        logic signed [63:0] cov_value;
        logic               last_in_row;
    } t_out;

    // Control tag that travels with each multiply-accumulate term.
    typedef struct packed {
        logic            vld;
        logic            first;
        logic            last_k;
        logic [IX_W-1:0] col;
        logic            last_col;
    } t_tag;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WSQ,
        S_WPRE,
        S_WCHK,
        S_WDIV,
        S_ISSUE,
        S_DRAIN
    } t_state;

endpackage

@@ src/svd_covariance_from_factors.sv @@
// ----------------------------------------------------------------------------
// svd_covariance_from_factors
// Covariance matrix C = V * diag(1/w^2) * V^T from SVD factors in fixed point.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                              | Direction | Flow control
//  --------+--------------------------------------+-----------+-------------
//  in      | i_in_valid, o_in_stall, i_in         | into      | valid/stall
//  out     | o_out_valid, i_out_stall, o_out      | out of    | valid/stall
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data | into      | valid/ready
//
//  A singular value load runs acceptance, square, numerator setup, a range check
//  and up to 32 restoring divider steps. One multiply-accumulate pipeline, fed by
//  two read ports of the factor memory, takes one term per cycle unless a valid
//  output is stalled. Reset clears the control state and sets n to 16; the
//  memories are not cleared. A stall on the output freezes the whole term pipeline.
//
module svd_covariance_from_factors #(
    parameter int MAX_N = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  svdcov_pkg::t_in                    i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output svdcov_pkg::t_out                   o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [svdcov_pkg::SIZE_W-1:0]      i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_N);
    localparam int ACC_W  = svdcov_pkg::ACC_W;
    localparam int RND_SH = svdcov_pkg::RND_SH;
    localparam int CAP_I  = (MAX_N < 16) ? MAX_N : 16;
    localparam logic [svdcov_pkg::SIZE_W-1:0] CAP = svdcov_pkg::SIZE_W'(CAP_I);
    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);

    // Storage.
    logic [31:0] mem_f [0:(1 << (2 * IDX_W)) - 1];
    logic [31:0] mem_w [0:(1 << IDX_W) - 1];

    // Control state.
    svdcov_pkg::t_state r_state, n_state;
    logic [svdcov_pkg::SIZE_W-1:0] r_size;
    logic [svdcov_pkg::IX_W-1:0]   r_row, r_n_m1, r_j, r_k;
    logic [4:0]                    r_cnt;
    logic                          r_row_ok;
    svdcov_pkg::t_tag              tag0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6;
    logic                          r_out_valid;

    // Weight divider datapath.
    logic [31:0] r_mag;
    logic [63:0] r_den;
    logic [62:0] r_rem;
    logic [31:0] r_numlo;
    logic [31:0] r_quo;
    logic [63:0] num;
    logic [63:0] trial;
    logic        q_bit;

    // Term pipeline datapath.
    logic signed [31:0]      r_fa, r_fb, r_ph3;
    logic [31:0]             r_wt1, r_wt2, r_wt3;
    logic signed [63:0]      r_p, r_phw;
    logic [63:0]             r_plw, r_pl4;
    logic signed [ACC_W-1:0] r_term, r_acc;
    logic [ACC_W-1:0]        rnd;
    svdcov_pkg::t_out        r_out;

    // Misc control.
    logic                          in_acc, en, issue, pipe_busy;
    logic                          f_we, wt_we;
    logic [31:0]                   wt_data;
    logic [svdcov_pkg::SIZE_W-1:0] n_eff;
    logic                          ld_row_ok, ld_col_ok, req_ok;

    // Effective matrix size from the register.
    always_comb begin
        if (r_size == '0) begin
            n_eff = svdcov_pkg::SIZE_W'(1);
        end else if (r_size > CAP) begin
            n_eff = CAP;
        end else begin
            n_eff = r_size;
        end
    end

    // Request decode.
    assign in_acc    = i_in_valid && !o_in_stall;
    assign ld_row_ok = 32'(i_in.row) < MAX_N;
    assign ld_col_ok = 32'(i_in.col) < MAX_N;
    assign req_ok    = {1'b0, i_in.row} < n_eff;
    assign f_we      = in_acc && (i_in.func == svdcov_pkg::FN_LOAD_V) && ld_row_ok && ld_col_ok;

    // The pipeline moves unless a finished result is held by the consumer.
    assign en        = !r_out_valid || !i_out_stall;
    assign pipe_busy = r_t1.vld || r_t2.vld || r_t3.vld || r_t4.vld || r_t5.vld || r_t6.vld;

    // Divider numerator and one restoring step.
    assign num   = 64'h0001_0000_0000_0000 + (r_den >> 1);
    assign trial = {r_rem, r_numlo[31]};
    assign q_bit = trial >= r_den;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svdcov_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in.func)
                        svdcov_pkg::FN_LOAD_W: n_state = svdcov_pkg::S_WSQ;
                        svdcov_pkg::FN_ROW: begin
                            if (req_ok) begin
                                n_state = svdcov_pkg::S_ISSUE;
                            end
                        end
                        default: n_state = svdcov_pkg::S_IDLE;
                    endcase
                end
            end
            svdcov_pkg::S_WSQ:  n_state = svdcov_pkg::S_WPRE;
            svdcov_pkg::S_WPRE: n_state = svdcov_pkg::S_WCHK;
            svdcov_pkg::S_WCHK: begin
                if (r_den == '0 || 64'(r_rem) >= r_den) begin
                    n_state = svdcov_pkg::S_IDLE;
                end else begin
                    n_state = svdcov_pkg::S_WDIV;
                end
            end
            svdcov_pkg::S_WDIV: begin
                if (r_cnt == '0) begin
                    n_state = svdcov_pkg::S_IDLE;
                end
            end
            svdcov_pkg::S_ISSUE: begin
                if (en && r_k == r_n_m1 && r_j == r_n_m1) begin
                    n_state = svdcov_pkg::S_DRAIN;
                end
            end
            svdcov_pkg::S_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = svdcov_pkg::S_IDLE;
                end
            end
            default: n_state = svdcov_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        wt_we      = 1'b0;
        wt_data    = '0;
        issue      = 1'b0;
        unique case (r_state)
            svdcov_pkg::S_IDLE: o_in_stall = 1'b0;
            svdcov_pkg::S_WCHK: begin
                if (r_den == '0) begin
                    wt_we = r_row_ok;
                end else if (64'(r_rem) >= r_den) begin
                    wt_we   = r_row_ok;
                    wt_data = svdcov_pkg::WT_SAT;
                end
            end
            svdcov_pkg::S_WDIV: begin
                if (r_cnt == '0) begin
                    wt_we   = r_row_ok;
                    wt_data = {r_quo[30:0], q_bit};
                end
            end
            svdcov_pkg::S_ISSUE: issue = 1'b1;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Tag of the term issued this cycle.
    always_comb begin
        tag0.vld      = issue;
        tag0.first    = (r_k == '0);
        tag0.last_k   = (r_k == r_n_m1);
        tag0.col      = r_j;
        tag0.last_col = (r_j == r_n_m1);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svdcov_pkg::S_IDLE;
            r_size      <= svdcov_pkg::SIZE_RST;
            r_j         <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_t1        <= '0;
            r_t2        <= '0;
            r_t3        <= '0;
            r_t4        <= '0;
            r_t5        <= '0;
            r_t6        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
            // Row request start and term sequencing.
            if (in_acc && i_in.func == svdcov_pkg::FN_ROW) begin
                r_j <= '0;
                r_k <= '0;
            end else if (issue && en) begin
                if (r_k == r_n_m1) begin
                    r_k <= '0;
                    r_j <= r_j + 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            // Division step counter.
            if (r_state == svdcov_pkg::S_WCHK) begin
                r_cnt <= 5'd31;
            end else if (r_state == svdcov_pkg::S_WDIV) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (en) begin
                r_t1        <= tag0;
                r_t2        <= r_t1;
                r_t3        <= r_t2;
                r_t4        <= r_t3;
                r_t5        <= r_t4;
                r_t6        <= r_t5;
                r_out_valid <= r_t6.vld && r_t6.last_k;
            end
        end
    end

    // Captured request fields and the weight divider.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row    <= i_in.row;
            r_row_ok <= ld_row_ok;
            r_n_m1   <= svdcov_pkg::IX_W'(n_eff - 1'b1);
            r_mag    <= (i_in.value < 0) ? 32'(-i_in.value) : 32'(i_in.value);
        end
        case (r_state)
            svdcov_pkg::S_WSQ: r_den <= r_mag * r_mag;
            svdcov_pkg::S_WPRE: begin
                r_rem   <= num[63:1] >> 31;
                r_numlo <= num[31:0];
                r_quo   <= '0;
            end
            svdcov_pkg::S_WDIV: begin
                r_rem   <= q_bit ? 63'(trial - r_den) : trial[62:0];
                r_numlo <= {r_numlo[30:0], 1'b0};
                r_quo   <= {r_quo[30:0], q_bit};
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // Factor memory: one write port, two read ports.
    always_ff @(posedge i_clk) begin
        if (f_we) begin
            mem_f[{IDX_W'(i_in.row), IDX_W'(i_in.col)}] <= i_in.value;
        end
        if (en) begin
            r_fa <= mem_f[{IDX_W'(r_row), IDX_W'(r_k)}];
            r_fb <= mem_f[{IDX_W'(r_j), IDX_W'(r_k)}];
        end
    end

    // Weight memory.
    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            mem_w[IDX_W'(r_row)] <= wt_data;
        end
        if (en) begin
            r_wt1 <= mem_w[IDX_W'(r_k)];
        end
    end

    // Term pipeline: V*V, low and high halves times the weight, combine, sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p    <= r_fa * r_fb;
            r_wt2  <= r_wt1;
            r_plw  <= r_p[31:0] * r_wt2;
            r_ph3  <= r_p[63:32];
            r_wt3  <= r_wt2;
            r_phw  <= r_ph3 * $signed({1'b0, r_wt3});
            r_pl4  <= r_plw;
            r_term <= (ACC_W'(r_phw) << 32) + ACC_W'(r_pl4);
            if (r_t5.vld) begin
                r_acc <= r_t5.first ? r_term : r_acc + r_term;
            end
        end
    end

    // Round half up to Q32.32; the sum range never needs saturation.
    assign rnd = r_acc + RND_HALF;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en && r_t6.vld && r_t6.last_k) begin
            r_out.out_row     <= r_row;
            r_out.out_col     <= r_t6.col;
            r_out.cov_value   <= 64'($signed(rnd[ACC_W-1:RND_SH]));
            r_out.last_in_row <= r_t6.last_col;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    // The term pipeline is empty whenever the sequencer rests.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svdcov_pkg::S_IDLE) |-> !pipe_busy)
        else $error("term pipeline busy while idle");

    // The weight memory is written only by the divider.
    a_wt_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wt_we |-> (r_state == svdcov_pkg::S_WCHK || r_state == svdcov_pkg::S_WDIV))
        else $error("weight write outside the divider");

    // The factor memory is never written while terms are read.
    a_f_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_we |-> (r_state == svdcov_pkg::S_IDLE && !pipe_busy))
        else $error("factor write during a row request");

    // The partial remainder stays below the divisor during division.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svdcov_pkg::S_WDIV) |-> (64'(r_rem) < r_den))
        else $error("divider remainder out of range");

    // Term indexes stay inside the matrix while issuing.
    a_issue_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_k <= r_n_m1 && r_j <= r_n_m1))
        else $error("term index beyond matrix size");

endmodule

@@ tb/svd_covariance_from_factors_test.sv @@
// ----------------------------------------------------------------------------
// svd_covariance_from_factors_test
// Self-checking bench for the covariance-from-SVD-factors block. It loads
// singular values and V elements, requests covariance rows under several
// matrix sizes, and checks every emitted element against a bit-exact
// fixed-point prediction held in the bench.
// ----------------------------------------------------------------------------
module svd_covariance_from_factors_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_N       = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int NUM_PHASES    = 9;

    // The selector value that the block ignores.
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // Size settings per phase, with the random request count of each.
    localparam int PHASE_SIZE [NUM_PHASES] = '{3, 0, 5, 16, 1, 31, 8, 4, 7};
    localparam int PHASE_REQS [NUM_PHASES] = '{24, 16, 24, 16, 16, 12, 20, 24, 32};

    typedef struct {
        svdcov_pkg::t_in req;
        bit              hold;
    } t_pending;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    svdcov_pkg::t_in               i_in        = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    svdcov_pkg::t_out              o_out;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [svdcov_pkg::SIZE_W-1:0] i_cfg_data  = '0;

    // Bench copy of the block state.
    logic [31:0]                   factor_model [STORE_N*STORE_N];
    logic [31:0]                   weight_model [STORE_N];
    logic [svdcov_pkg::SIZE_W-1:0] model_size = svdcov_pkg::SIZE_RST;

    // Entries already loaded, so that no row request reads an unwritten one.
    bit v_written [STORE_N][STORE_N];
    bit w_written [STORE_N];

    t_pending         requests_to_send [$];
    svdcov_pkg::t_out elements_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int requests_accepted = 0;
    int rows_requested = 0;
    int elements_checked = 0;
    int size_writes = 0;
    int cycle_count = 0;

    svd_covariance_from_factors #(
        .MAX_N(STORE_N)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Size zero acts as one, sizes above the store act as the store size.
    function automatic int unsigned active_size(logic [svdcov_pkg::SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > STORE_N)
            return STORE_N;
        return s;
    endfunction

    // 1/w^2 in unsigned Q16.16, rounded half up, saturated; zero for w = 0.
    function automatic logic [31:0] inverse_square(logic signed [31:0] w);
        logic signed [63:0] ws;
        logic [63:0]        mag;
        logic [63:0]        sq;
        logic [63:0]        q;
        ws = w;
        mag = (ws < 0) ? -ws : ws;
        if (mag == 0)
            return '0;
        sq = mag * mag;
        q = ((64'd1 << 48) + sq / 2) / sq;
        return (q > 64'hFFFF_FFFF) ? svdcov_pkg::WT_SAT : q[31:0];
    endfunction

    // One covariance element: exact sum of Q20.76 terms, rounded to Q32.32.
    function automatic logic signed [63:0] cov_element(int unsigned i, int unsigned j,
                                                       int unsigned n);
        logic signed [127:0] acc;
        logic signed [127:0] p;
        logic signed [127:0] rs;
        logic signed [31:0]  a;
        logic signed [31:0]  b;
        acc = '0;
        for (int unsigned k = 0; k < n; k++) begin
            a = factor_model[i*STORE_N + k];
            b = factor_model[j*STORE_N + k];
            p = a * b;
            acc = acc + p * $signed({96'd0, weight_model[k]});
        end
        rs = acc + (128'sd1 <<< 43);
        if ((&rs[127:107]) || !(|rs[127:107]))
            return rs[107:44];
        return rs[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    // Apply one accepted request to the bench state and queue its elements.
    task automatic apply_to_factor_model(svdcov_pkg::t_in req);
        int unsigned      n;
        svdcov_pkg::t_out e;
        case (req.func)
            svdcov_pkg::FN_LOAD_W: begin
                weight_model[req.row] = inverse_square(req.value);
            end
            svdcov_pkg::FN_LOAD_V: begin
                factor_model[{req.row, req.col}] = req.value;
            end
            svdcov_pkg::FN_ROW: begin
                n = active_size(model_size);
                if (req.row < n) begin
                    rows_requested++;
                    for (int unsigned j = 0; j < n; j++) begin
                        e.out_row     = req.row;
                        e.out_col     = 4'(j);
                        e.cov_value   = cov_element(req.row, j, n);
                        e.last_in_row = (j == n - 1);
                        elements_due.push_back(e);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // Request driver: presents the queued requests with random gaps.
    always @(posedge i_clk) begin : request_drive
        t_pending next_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_to_factor_model(i_in);
                requests_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (requests_to_send.size() == 0 ||
                    $urandom_range(99) < send_idle_pct ||
                    (requests_to_send[0].hold && elements_due.size() != 0)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    next_req   = requests_to_send.pop_front();
                    i_in       <= next_req.req;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // Output back-pressure.
    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // Element checker: each accepted element against the oldest prediction.
    always @(posedge i_clk) begin : element_check
        svdcov_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (elements_due.size() == 0) begin
                report_mismatch($sformatf("unexpected element row %0d col %0d",
                                          o_out.out_row, o_out.out_col));
            end else begin
                want = elements_due.pop_front();
                elements_checked++;
                if (o_out.out_row !== want.out_row)
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              o_out.out_row, want.out_row));
                if (o_out.out_col !== want.out_col)
                    report_mismatch($sformatf("out_col %0d, expected %0d",
                                              o_out.out_col, want.out_col));
                if (o_out.cov_value !== want.cov_value)
                    report_mismatch($sformatf("C[%0d][%0d] = %h, expected %h",
                                              want.out_row, want.out_col,
                                              o_out.cov_value, want.cov_value));
                if (o_out.last_in_row !== want.last_in_row)
                    report_mismatch($sformatf("last_in_row %b, expected %b at C[%0d][%0d]",
                                              o_out.last_in_row, want.last_in_row,
                                              want.out_row, want.out_col));
            end
        end
    end

    task automatic queue_request(logic [1:0] fn, int r, int c, logic [31:0] v,
                                 bit hold = 1'b0);
        t_pending p;
        p.req.func  = fn;
        p.req.row   = 4'(r);
        p.req.col   = 4'(c);
        p.req.value = v;
        p.hold      = hold;
        if (fn == svdcov_pkg::FN_LOAD_V)
            v_written[r][c] = 1'b1;
        if (fn == svdcov_pkg::FN_LOAD_W)
            w_written[r] = 1'b1;
        requests_to_send.push_back(p);
    endtask

    // V element: mostly within +-1.0, some raw words, some extremes.
    function automatic logic [31:0] rand_factor();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
        if (sel < 85)
            return $urandom;
        case ($urandom_range(4))
            0:       return 32'h4000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Singular value: mostly 0.25 to 64, some raw words, zeros and tiny ones.
    function automatic logic [31:0] rand_weight();
        int unsigned sel;
        logic [31:0] mag;
        sel = $urandom_range(99);
        if (sel < 70 && sel >= 50)
            return $urandom;
        if (sel < 80 && sel >= 70)
            return '0;
        if (sel < 50)
            mag = $urandom_range(32'h0040_0000, 32'h0000_4000);
        else
            mag = $urandom_range(255, 1);
        return $urandom_range(1) ? (32'd0 - mag) : mag;
    endfunction

    // Load every entry that a row request of size n reads and that is unset.
    task automatic fill_unwritten(int unsigned n);
        for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = 0; c < n; c++)
                if (!v_written[r][c])
                    queue_request(svdcov_pkg::FN_LOAD_V, r, c, rand_factor());
        for (int unsigned k = 0; k < n; k++)
            if (!w_written[k])
                queue_request(svdcov_pkg::FN_LOAD_W, k, $urandom_range(15), rand_weight());
    endtask

    task automatic queue_random(int unsigned n);
        int unsigned sel;
        bit          hold;
        sel  = $urandom_range(99);
        hold = ($urandom_range(49) == 0);
        if (sel < 15)
            queue_request(svdcov_pkg::FN_LOAD_W, $urandom_range(15), $urandom_range(15),
                          rand_weight(), hold);
        else if (sel < 55)
            queue_request(svdcov_pkg::FN_LOAD_V, $urandom_range(15), $urandom_range(15),
                          rand_factor(), hold);
        else if (sel < 88)
            queue_request(svdcov_pkg::FN_ROW, $urandom_range(n - 1), $urandom_range(15),
                          $urandom, hold);
        else if (sel < 94)
            queue_request(svdcov_pkg::FN_ROW, $urandom_range(15), $urandom_range(15),
                          $urandom, hold);
        else
            queue_request(FN_UNUSED, $urandom_range(15), $urandom_range(15), $urandom, hold);
    endtask

    // Wait until every request is sent and answered, then let loads finish.
    task automatic wait_idle();
        while (requests_to_send.size() != 0 || i_in_valid || elements_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(logic [svdcov_pkg::SIZE_W-1:0] s);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= s;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_size = s;
        size_writes++;
    endtask

    // Main sequence.
    initial begin
        int unsigned n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 30;
        recv_idle_pct = 52;

        // Directed part on a 2x2 system.
        write_size(5'd2);
        queue_request(svdcov_pkg::FN_LOAD_W, 0, 0, 32'h0001_0000);
        queue_request(svdcov_pkg::FN_LOAD_W, 1, 15, 32'h0000_0001);
        queue_request(svdcov_pkg::FN_LOAD_V, 0, 0, 32'h4000_0000);
        queue_request(svdcov_pkg::FN_LOAD_V, 0, 1, 32'h8000_0000);
        queue_request(svdcov_pkg::FN_LOAD_V, 1, 0, 32'h7FFF_FFFF);
        queue_request(svdcov_pkg::FN_LOAD_V, 1, 1, 32'hC000_0000);
        queue_request(svdcov_pkg::FN_ROW, 0, 15, 32'hFFFF_FFFF);
        queue_request(svdcov_pkg::FN_ROW, 1, 0, 32'h0000_0000);
        queue_request(FN_UNUSED, 15, 15, 32'hFFFF_FFFF);
        // Rows at or beyond the size emit nothing.
        queue_request(svdcov_pkg::FN_ROW, 2, 0, 32'h0);
        queue_request(svdcov_pkg::FN_ROW, 15, 0, 32'h0);
        // Loads beyond the size but inside the store are kept.
        queue_request(svdcov_pkg::FN_LOAD_W, 15, 0, 32'h8000_0000, 1'b1);
        queue_request(svdcov_pkg::FN_LOAD_W, 14, 0, 32'h7FFF_FFFF);
        queue_request(svdcov_pkg::FN_LOAD_W, 13, 0, 32'hFFFF_FFFF);
        queue_request(svdcov_pkg::FN_LOAD_V, 15, 15, 32'hFFFF_FFFF);
        queue_request(svdcov_pkg::FN_LOAD_V, 9, 12, 32'h0000_0000);
        // A zero singular value gives a zero weight.
        queue_request(svdcov_pkg::FN_LOAD_W, 1, 0, 32'h0000_0000);
        queue_request(svdcov_pkg::FN_ROW, 1, 0, 32'h0, 1'b1);
        queue_request(svdcov_pkg::FN_LOAD_V, 0, 0, 32'hFFFF_FFFF);
        queue_request(svdcov_pkg::FN_LOAD_W, 0, 0, 32'hFFFF_0000);
        queue_request(svdcov_pkg::FN_ROW, 0, 0, 32'h0);
        queue_request(svdcov_pkg::FN_ROW, 1, 0, 32'h0);

        // Random part over several sizes and idle patterns.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 52;
                recv_idle_pct = 30;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_size(svdcov_pkg::SIZE_W'(PHASE_SIZE[p]));
            n = active_size(svdcov_pkg::SIZE_W'(PHASE_SIZE[p]));
            fill_unwritten(n);
            repeat (PHASE_REQS[p]) queue_random(n);
        end

        wait_idle();
        $display("Run covered %0d requests, %0d row requests, %0d elements checked.",
                 requests_accepted, rows_requested, elements_checked);
        $display("Size register written %0d times with sizes from 0 to 31, three idle patterns.",
                 size_writes);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
